// File: rtl/sa16_pkg.sv
// sa16_pkg: types, command codes and sizes for the 16-bit stack ALU.
// Used by sa16_mdu, stack_alu_16bit_core and sa16_checker; depends on nothing.
`default_nettype none
package sa16_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [4:0] CMD_PUSH = 5'd0;
  localparam logic [4:0] CMD_ADD  = 5'd1;
  localparam logic [4:0] CMD_MUL  = 5'd2;
  localparam logic [4:0] CMD_DIV  = 5'd3;
  localparam logic [4:0] CMD_SUB  = 5'd4;
  localparam logic [4:0] CMD_AND  = 5'd5;
  localparam logic [4:0] CMD_INV  = 5'd6;
  localparam logic [4:0] CMD_XOR  = 5'd7;
  localparam logic [4:0] CMD_OR   = 5'd8;
  localparam logic [4:0] CMD_GT   = 5'd9;
  localparam logic [4:0] CMD_LT   = 5'd10;
  localparam logic [4:0] CMD_GE   = 5'd11;
  localparam logic [4:0] CMD_LE   = 5'd12;
  localparam logic [4:0] CMD_SHR  = 5'd13;
  localparam logic [4:0] CMD_SHL  = 5'd14;
  localparam logic [4:0] CMD_EQ   = 5'd15;
  localparam logic [4:0] CMD_NE   = 5'd16;
  localparam logic [4:0] CMD_LOR  = 5'd17;
  localparam logic [4:0] CMD_LAND = 5'd18;
  localparam logic [4:0] CMD_LNOT = 5'd19;
  localparam logic [4:0] CMD_LXOR = 5'd20;
  localparam logic [4:0] CMD_DADD = 5'd21;
  localparam logic [4:0] CMD_DSUB = 5'd22;
  localparam logic [4:0] CMD_DMUL = 5'd23;
  localparam logic [4:0] CMD_DDIV = 5'd24;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [15:0] literal_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] top_value;
    logic [15:0] second_value;
    logic [6:0]  stack_depth;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

endpackage
`default_nettype wire

// File: rtl/sa16_stack_ram.sv
// sa16_stack_ram: single write port, single registered read port memory.
// Generic; no package dependency.
`default_nettype none
module sa16_stack_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/sa16_mdu.sv
// sa16_mdu: iterative 32x16 shift-add multiplier and 32/16 restoring divider.
// Depends on sa16_pkg for the request struct.
`default_nettype none
module sa16_mdu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sa16_pkg::mdu_req_t req_i,
  input  wire logic [31:0]       a_i,
  input  wire logic [15:0]       b_i,
  output logic                   done_o,
  output logic [31:0]            res_o
);

  logic        busy_q;
  logic        done_q;
  logic        is_div_q;
  logic [4:0]  cnt_q;
  logic [31:0] acc_q;
  logic [31:0] a_q;
  logic [15:0] b_q;
  logic [15:0] rem_q;
  logic [16:0] shl_rem;
  logic        fits;

  assign shl_rem = {rem_q, a_q[31]};
  assign fits    = shl_rem >= {1'b0, b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q   <= 1'b1;
        is_div_q <= req_i.is_div;
        cnt_q    <= req_i.is_div ? 5'd31 : 5'd15;
        acc_q    <= '0;
        a_q      <= a_i;
        b_q      <= b_i;
        rem_q    <= '0;
      end else if (busy_q) begin
        if (is_div_q) begin
          rem_q <= fits ? 16'(shl_rem - {1'b0, b_q}) : shl_rem[15:0];
          a_q   <= {a_q[30:0], fits};
        end else begin
          if (b_q[0]) begin
            acc_q <= acc_q + a_q;
          end
          a_q <= {a_q[30:0], 1'b0};
          b_q <= {1'b0, b_q[15:1]};
        end
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = is_div_q ? a_q : acc_q;

endmodule
`default_nettype wire

// File: rtl/stack_alu_16bit_core.sv
// stack_alu_16bit_core: top level of the 16-bit data-stack ALU.
// Depends on sa16_pkg, sa16_stack_ram and sa16_mdu.
//
//  channel | dir | payload              | handshake
//  in      | in  | sa16_pkg::in_item_t  | in_valid_i / in_stall_o
//  out     | out | sa16_pkg::out_item_t | out_valid_o / out_stall_i
//
// One item at a time: an address and a data state per operand read, a
// compute state, one or two stack writes, address and data states to read
// back top and second, then an output state. Mul and div wait in S_MDU on
// the 32-step divider or the multiplier in the shared mul/div unit.
// Reset empties the stack; store contents are not cleared.
// in_stall_o is high from acceptance until the result is loaded to the
// output register; a stalled output holds the next result back.
`default_nettype none
module stack_alu_16bit_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire sa16_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output sa16_pkg::out_item_t      out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_ADDR, S_RD_DATA, S_CALC, S_MDU, S_WR_HI, S_WR_LO,
    S_TOP_ADDR, S_TOP_DATA, S_SEC_ADDR, S_SEC_DATA, S_OUT
  } state_e;

  localparam int unsigned AW = sa16_pkg::ADDR_W;
  localparam int unsigned CW = sa16_pkg::CNT_W;

  function automatic logic [2:0] need_count(input logic [4:0] c);
    logic [2:0] n;
    case (c)
      sa16_pkg::CMD_PUSH: n = 3'd0;
      sa16_pkg::CMD_INV, sa16_pkg::CMD_SHR,
      sa16_pkg::CMD_SHL, sa16_pkg::CMD_LNOT: n = 3'd1;
      sa16_pkg::CMD_DADD, sa16_pkg::CMD_DSUB: n = 3'd4;
      sa16_pkg::CMD_DMUL, sa16_pkg::CMD_DDIV: n = 3'd3;
      default: n = (c <= sa16_pkg::CMD_LXOR) ? 3'd2 : 3'd0;
    endcase
    return n;
  endfunction

  state_e              state_q;
  logic [4:0]          cmd_q;
  logic [CW-1:0]       depth_q;
  logic [1:0]          status_q;
  logic [2:0]          need_q;
  logic [1:0]          rd_k_q;
  logic [15:0]         opnd_q [4];
  logic [31:0]         res_q;
  logic                two_q;
  logic [15:0]         top_q;
  logic [15:0]         sec_q;
  logic                out_valid_q;
  sa16_pkg::out_item_t out_q;

  logic [2:0]          in_need;
  logic [CW-1:0]       base;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [15:0]         wdata;
  logic [AW-1:0]       raddr;
  logic [15:0]         rdata;
  sa16_pkg::mdu_req_t  mdu_req;
  logic [31:0]         mdu_a;
  logic                mdu_done;
  logic [31:0]         mdu_res;
  logic [15:0]         t_w;
  logic [15:0]         s_w;
  logic [15:0]         simple;
  logic                div_zero;

  assign in_need  = need_count(in_data_i.cmd);
  assign base     = depth_q - CW'(need_q);
  assign t_w      = opnd_q[0];
  assign s_w      = opnd_q[1];
  assign div_zero = (t_w == 16'd0);

  always_comb begin
    case (cmd_q)
      sa16_pkg::CMD_ADD:  simple = s_w + t_w;
      sa16_pkg::CMD_SUB:  simple = s_w - t_w;
      sa16_pkg::CMD_AND:  simple = s_w & t_w;
      sa16_pkg::CMD_INV:  simple = ~t_w;
      sa16_pkg::CMD_XOR:  simple = s_w ^ t_w;
      sa16_pkg::CMD_OR:   simple = s_w | t_w;
      sa16_pkg::CMD_GT:   simple = 16'($signed(s_w) > $signed(t_w));
      sa16_pkg::CMD_LT:   simple = 16'($signed(s_w) < $signed(t_w));
      sa16_pkg::CMD_GE:   simple = 16'($signed(s_w) >= $signed(t_w));
      sa16_pkg::CMD_LE:   simple = 16'($signed(s_w) <= $signed(t_w));
      sa16_pkg::CMD_SHR:  simple = {1'b0, t_w[15:1]};
      sa16_pkg::CMD_SHL:  simple = {t_w[14:0], 1'b0};
      sa16_pkg::CMD_EQ:   simple = 16'(s_w == t_w);
      sa16_pkg::CMD_NE:   simple = 16'(s_w != t_w);
      sa16_pkg::CMD_LOR:  simple = 16'((s_w != 16'd0) || (t_w != 16'd0));
      sa16_pkg::CMD_LAND: simple = 16'((s_w != 16'd0) && (t_w != 16'd0));
      sa16_pkg::CMD_LNOT: simple = 16'(t_w == 16'd0);
      sa16_pkg::CMD_LXOR: simple = 16'((s_w != 16'd0) != (t_w != 16'd0));
      default:            simple = 16'd0;
    endcase
  end

  always_comb begin
    mdu_req.is_div = (cmd_q == sa16_pkg::CMD_DIV) || (cmd_q == sa16_pkg::CMD_DDIV);
    mdu_req.start  = 1'b0;
    if (state_q == S_CALC) begin
      case (cmd_q)
        sa16_pkg::CMD_MUL, sa16_pkg::CMD_DMUL: mdu_req.start = 1'b1;
        sa16_pkg::CMD_DIV, sa16_pkg::CMD_DDIV: mdu_req.start = !div_zero;
        default:                               mdu_req.start = 1'b0;
      endcase
    end
    mdu_a = (cmd_q == sa16_pkg::CMD_DMUL || cmd_q == sa16_pkg::CMD_DDIV)
            ? {opnd_q[2], opnd_q[1]} : {16'd0, opnd_q[1]};
  end

  always_comb begin
    we    = (state_q == S_WR_HI) || (state_q == S_WR_LO);
    waddr = (state_q == S_WR_HI) ? AW'(base) : AW'(base + CW'(two_q));
    wdata = (state_q == S_WR_HI) ? res_q[31:16] : res_q[15:0];
    case (state_q)
      S_RD_ADDR:  raddr = AW'(depth_q - CW'(rd_k_q) - CW'(1));
      S_TOP_ADDR: raddr = AW'(depth_q - CW'(1));
      S_SEC_ADDR: raddr = AW'(depth_q - CW'(2));
      default:    raddr = '0;
    endcase
  end

  sa16_stack_ram #(
    .DEPTH (sa16_pkg::STACK_DEPTH),
    .WIDTH (16)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sa16_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .a_i    (mdu_a),
    .b_i    (opnd_q[0]),
    .done_o (mdu_done),
    .res_o  (mdu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q    <= in_data_i.cmd;
            need_q   <= in_need;
            rd_k_q   <= 2'd0;
            status_q <= sa16_pkg::ST_OK;
            res_q    <= {16'd0, in_data_i.literal_value};
            two_q    <= 1'b0;
            if (in_data_i.cmd > sa16_pkg::CMD_DDIV) begin
              state_q <= S_TOP_ADDR;
            end else if (in_data_i.cmd == sa16_pkg::CMD_PUSH) begin
              if (depth_q == CW'(sa16_pkg::STACK_DEPTH)) begin
                status_q <= sa16_pkg::ST_OVER;
                state_q  <= S_TOP_ADDR;
              end else begin
                state_q <= S_WR_LO;
              end
            end else if (depth_q < CW'(in_need)) begin
              status_q <= sa16_pkg::ST_UNDER;
              state_q  <= S_TOP_ADDR;
            end else begin
              state_q <= S_RD_ADDR;
            end
          end
        end
        S_RD_ADDR: state_q <= S_RD_DATA;
        S_RD_DATA: begin
          opnd_q[rd_k_q] <= rdata;
          if ({1'b0, rd_k_q} + 3'd1 == need_q) begin
            state_q <= S_CALC;
          end else begin
            rd_k_q  <= rd_k_q + 2'd1;
            state_q <= S_RD_ADDR;
          end
        end
        S_CALC: begin
          two_q <= (cmd_q >= sa16_pkg::CMD_DADD);
          case (cmd_q)
            sa16_pkg::CMD_MUL, sa16_pkg::CMD_DMUL: state_q <= S_MDU;
            sa16_pkg::CMD_DIV, sa16_pkg::CMD_DDIV: begin
              if (div_zero) begin
                status_q <= sa16_pkg::ST_DIVZ;
                state_q  <= S_TOP_ADDR;
              end else begin
                state_q <= S_MDU;
              end
            end
            sa16_pkg::CMD_DADD: begin
              res_q   <= {opnd_q[3], opnd_q[2]} + {opnd_q[1], opnd_q[0]};
              state_q <= S_WR_HI;
            end
            sa16_pkg::CMD_DSUB: begin
              res_q   <= {opnd_q[3], opnd_q[2]} - {opnd_q[1], opnd_q[0]};
              state_q <= S_WR_HI;
            end
            default: begin
              res_q   <= {16'd0, simple};
              state_q <= S_WR_LO;
            end
          endcase
        end
        S_MDU: begin
          if (mdu_done) begin
            res_q   <= mdu_res;
            state_q <= two_q ? S_WR_HI : S_WR_LO;
          end
        end
        S_WR_HI: state_q <= S_WR_LO;
        S_WR_LO: begin
          depth_q <= base + CW'(two_q) + CW'(1);
          state_q <= S_TOP_ADDR;
        end
        S_TOP_ADDR: state_q <= S_TOP_DATA;
        S_TOP_DATA: begin
          top_q   <= (depth_q >= CW'(1)) ? rdata : 16'd0;
          state_q <= S_SEC_ADDR;
        end
        S_SEC_ADDR: state_q <= S_SEC_DATA;
        S_SEC_DATA: begin
          sec_q   <= (depth_q >= CW'(2)) ? rdata : 16'd0;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.top_value    <= top_q;
            out_q.second_value <= sec_q;
            out_q.stack_depth  <= 7'(depth_q);
            out_q.status       <= status_q;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: rtl/sa16_checker.sv
// sa16_checker: port-level assertions for stack_alu_16bit_core, and its bind.
// Depends on sa16_pkg.
`default_nettype none
module sa16_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire sa16_pkg::out_item_t out_data_o
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result item changed");

  a_depth_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.stack_depth <= 7'(sa16_pkg::STACK_DEPTH))
    else $error("depth beyond stack size");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stack_depth == 7'd0
      |-> out_data_o.top_value == 16'd0 && out_data_o.second_value == 16'd0)
    else $error("empty stack shows values");

  a_single_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stack_depth == 7'd1 |-> out_data_o.second_value == 16'd0)
    else $error("absent second entry non-zero");

endmodule

bind stack_alu_16bit_core sa16_checker u_sa16_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
